FILE: hw/rtl/rfrc_pkg.sv
// Shared types, codes and defaults of the redundancy frame receive checker.
// Depends on nothing; every other file of the block imports it.
package rfrc_pkg;

    // Default sizing of the block
    localparam int RFRC_PORTS   = 4;
    localparam int RFRC_MAX_LEN = 1024;

    // Fixed field widths
    localparam int PORT_W   = 4;
    localparam int CFG_LEN_W = 11;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // Item modes
    localparam logic [1:0] MODE_FRAME  = 2'd0;
    localparam logic [1:0] MODE_POLL   = 2'd1;
    localparam logic [1:0] MODE_PERIOD = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_ACCEPT    = 3'd0;
    localparam logic [2:0] ST_SRC_ERR   = 3'd1;
    localparam logic [2:0] ST_LEN_ERR   = 3'd2;
    localparam logic [2:0] ST_POLL_DONE = 3'd3;
    localparam logic [2:0] ST_POLL_BAD  = 3'd4;
    localparam logic [2:0] ST_PERIOD    = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_EXPECTED_SLOT   = 2'd0;
    localparam logic [1:0] REG_FRAME_TYPE_CODE = 2'd1;
    localparam logic [1:0] REG_FIRST_PORT      = 2'd2;
    localparam logic [1:0] REG_CONFIGURED_LEN  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic        right_train;
        logic [7:0]  delivered_slot;
        logic [7:0]  frame_type;
        logic [7:0]  header_slot;
        logic [7:0]  source_port;
        logic [15:0] frame_len;
        logic [15:0] frame_seq;
        logic [31:0] frame_tag;
        logic [7:0]  poll_port;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  port;
        logic        repeat_res;
        logic        in_sequence;
        logic        data_held;
        logic [31:0] lost_count;
        logic [31:0] good_count;
        logic [31:0] held_tag;
        logic [31:0] ok_total;
        logic [31:0] repeat_total;
        logic [31:0] source_err_total;
        logic [31:0] length_err_total;
    } t_out_word;

    typedef struct packed {
        logic [7:0]           expected_slot;
        logic [7:0]           frame_type_code;
        logic [7:0]           first_port;
        logic [CFG_LEN_W-1:0] configured_len;
    } t_cfg;

    // Classification of one word, handed from the checker to the port state
    typedef struct packed {
        logic              has_result;
        logic [2:0]        status;
        logic              port_known;
        logic [PORT_W-1:0] pidx;
    } t_chk;

endpackage

FILE: hw/rtl/redundant_frame_rx_checker_core.sv
// Redundancy frame receive checker, top level.
// A word passes the input register, then the result register, before its result
// is valid; one word per cycle is sustained while the output is not stalled, set by
// the per-port state update that lies between the two registers.
// Reset (synchronous, active low) clears all port state, totals, configuration
// registers and both pipeline valids. Depends on rfrc_pkg and the rfrc_* modules.
module redundant_frame_rx_checker_core #(
    parameter int PORTS   = rfrc_pkg::RFRC_PORTS,
    parameter int MAX_LEN = rfrc_pkg::RFRC_MAX_LEN
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  rfrc_pkg::t_in_word          i_in_word,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output rfrc_pkg::t_out_word         o_out_word,
    input  logic                        i_out_stall,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rfrc_pkg::APB_AW-1:0] paddr,
    input  logic [rfrc_pkg::APB_DW-1:0] pwdata,
    output logic [rfrc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import rfrc_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      advance;
    t_cfg      cfg;
    t_chk      chk;
    t_out_word result;

    // Move the held word forward when the result slot is free
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    rfrc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rfrc_frame_check #(
        .PORTS   (PORTS),
        .MAX_LEN (MAX_LEN)
    ) u_check (
        .i_word (r_in_word),
        .i_cfg  (cfg),
        .o_chk  (chk)
    );

    rfrc_port_state #(
        .PORTS   (PORTS),
        .MAX_LEN (MAX_LEN)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_word   (r_in_word),
        .i_chk    (chk),
        .o_result (result)
    );

    // Result register; a word of unused mode leaves no result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= chk.has_result;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: hw/rtl/rfrc_cfg_regs.sv
// APB configuration registers of the redundancy frame receive checker.
// Depends on rfrc_pkg.
module rfrc_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rfrc_pkg::APB_AW-1:0] paddr,
    input  logic [rfrc_pkg::APB_DW-1:0] pwdata,
    output logic [rfrc_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output rfrc_pkg::t_cfg             o_cfg
);
    import rfrc_pkg::*;

    logic [7:0]           r_expected_slot;
    logic [7:0]           r_frame_type_code;
    logic [7:0]           r_first_port;
    logic [CFG_LEN_W-1:0] r_configured_len;
    logic [1:0]           reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write the addressed register in the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_slot   <= '0;
            r_frame_type_code <= '0;
            r_first_port      <= '0;
            r_configured_len  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_EXPECTED_SLOT:   r_expected_slot   <= pwdata[7:0];
                REG_FRAME_TYPE_CODE: r_frame_type_code <= pwdata[7:0];
                REG_FIRST_PORT:      r_first_port      <= pwdata[7:0];
                REG_CONFIGURED_LEN:  r_configured_len  <= pwdata[CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_idx)
            REG_EXPECTED_SLOT:   prdata = {24'd0, r_expected_slot};
            REG_FRAME_TYPE_CODE: prdata = {24'd0, r_frame_type_code};
            REG_FIRST_PORT:      prdata = {24'd0, r_first_port};
            REG_CONFIGURED_LEN:  prdata = {{(APB_DW-CFG_LEN_W){1'b0}}, r_configured_len};
            default:             prdata = '0;
        endcase
    end

    assign o_cfg.expected_slot   = r_expected_slot;
    assign o_cfg.frame_type_code = r_frame_type_code;
    assign o_cfg.first_port      = r_first_port;
    assign o_cfg.configured_len  = r_configured_len;

endmodule

FILE: hw/rtl/rfrc_frame_check.sv
// Header source and length checks, poll port range check: classifies a word.
// Depends on rfrc_pkg.
module rfrc_frame_check #(
    parameter int PORTS   = rfrc_pkg::RFRC_PORTS,
    parameter int MAX_LEN = rfrc_pkg::RFRC_MAX_LEN
) (
    input  rfrc_pkg::t_in_word i_word,
    input  rfrc_pkg::t_cfg     i_cfg,
    output rfrc_pkg::t_chk     o_chk
);
    import rfrc_pkg::*;

    localparam logic [15:0] MaxLen16 = 16'(MAX_LEN);
    localparam logic [8:0]  Ports9   = 9'(PORTS);

    logic [7:0]  port_diff;
    logic        src_ok;
    logic [15:0] cfg_len16;
    logic [15:0] eff_len;
    logic        len_err;
    logic        poll_ok;

    // Source: train, both slots, type and port window
    assign port_diff = i_word.source_port - i_cfg.first_port;
    assign src_ok = i_word.right_train
                 && (i_word.delivered_slot == i_cfg.expected_slot)
                 && (i_word.frame_type == i_cfg.frame_type_code)
                 && (i_word.header_slot == i_cfg.expected_slot)
                 && (i_word.source_port >= i_cfg.first_port)
                 && ({1'b0, port_diff} < Ports9);

    // Length: check against the clamped configured length if set, and 1..MAX_LEN
    assign cfg_len16 = {{(16-CFG_LEN_W){1'b0}}, i_cfg.configured_len};
    assign eff_len   = (cfg_len16 > MaxLen16) ? MaxLen16 : cfg_len16;
    assign len_err   = ((eff_len != 16'd0) && (i_word.frame_len != eff_len))
                    || (i_word.frame_len == 16'd0)
                    || (i_word.frame_len > MaxLen16);

    assign poll_ok = ({1'b0, i_word.poll_port} < Ports9);

    always_comb begin
        o_chk = '0;
        case (i_word.mode)
            MODE_FRAME: begin
                o_chk.has_result = 1'b1;
                if (!src_ok) begin
                    o_chk.status = ST_SRC_ERR;
                end else begin
                    o_chk.port_known = 1'b1;
                    o_chk.pidx       = port_diff[PORT_W-1:0];
                    o_chk.status     = len_err ? ST_LEN_ERR : ST_ACCEPT;
                end
            end
            MODE_POLL: begin
                o_chk.has_result = 1'b1;
                if (!poll_ok) begin
                    o_chk.status = ST_POLL_BAD;
                end else begin
                    o_chk.status     = ST_POLL_DONE;
                    o_chk.port_known = 1'b1;
                    o_chk.pidx       = i_word.poll_port[PORT_W-1:0];
                end
            end
            MODE_PERIOD: begin
                o_chk.has_result = 1'b1;
                o_chk.status     = ST_PERIOD;
            end
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/rfrc_port_state.sv
// Per-port sequence, repeat, tag and poll state plus the global totals.
// Updates on each advancing word and builds its result. Depends on rfrc_pkg.
module rfrc_port_state #(
    parameter int PORTS   = rfrc_pkg::RFRC_PORTS,
    parameter int MAX_LEN = rfrc_pkg::RFRC_MAX_LEN
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  rfrc_pkg::t_in_word  i_word,
    input  rfrc_pkg::t_chk      i_chk,
    output rfrc_pkg::t_out_word o_result
);
    import rfrc_pkg::*;

    localparam int PIDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int LEN_W  = $clog2(MAX_LEN + 1);

    logic [15:0]      r_seq_base  [PORTS];
    logic             r_held_valid[PORTS];
    logic [LEN_W-1:0] r_held_len  [PORTS];
    logic [31:0]      r_tag       [PORTS];
    logic             r_seq_ok    [PORTS];
    logic             r_prev_ok   [PORTS];
    logic [31:0]      r_prev_tag  [PORTS];
    logic             r_polled    [PORTS];
    logic [31:0]      r_lost      [PORTS];
    logic [31:0]      r_good      [PORTS];
    logic [31:0]      r_ok_total;
    logic [31:0]      r_rep_total;
    logic [31:0]      r_src_total;
    logic [31:0]      r_len_total;

    logic [PIDX_W-1:0] sel;
    logic [15:0]       n_seq_base;
    logic              n_held_valid;
    logic [LEN_W-1:0]  n_held_len;
    logic [31:0]       n_tag;
    logic              n_seq_ok;
    logic              n_prev_ok;
    logic [31:0]       n_prev_tag;
    logic              n_polled;
    logic [31:0]       n_lost;
    logic [31:0]       n_good;
    logic [31:0]       n_ok_total;
    logic [31:0]       n_rep_total;
    logic [31:0]       n_src_total;
    logic [31:0]       n_len_total;
    logic              rep;
    logic              stale;

    assign sel = i_chk.pidx[PIDX_W-1:0];

    // Next state of the selected port and of the totals
    always_comb begin
        n_seq_base   = r_seq_base[sel];
        n_held_valid = r_held_valid[sel];
        n_held_len   = r_held_len[sel];
        n_tag        = r_tag[sel];
        n_seq_ok     = r_seq_ok[sel];
        n_prev_ok    = r_prev_ok[sel];
        n_prev_tag   = r_prev_tag[sel];
        n_polled     = r_polled[sel];
        n_lost       = r_lost[sel];
        n_good       = r_good[sel];
        n_ok_total   = r_ok_total;
        n_rep_total  = r_rep_total;
        n_src_total  = r_src_total;
        n_len_total  = r_len_total;
        rep          = 1'b0;
        stale        = 1'b0;
        if (i_chk.has_result) begin
            case (i_chk.status)
                ST_ACCEPT: begin
                    rep = r_held_valid[sel]
                       && ({{(16-LEN_W){1'b0}}, r_held_len[sel]} == i_word.frame_len)
                       && (r_tag[sel] == i_word.frame_tag);
                    n_tag = i_word.frame_tag;
                    if (i_word.frame_seq == r_seq_base[sel] + 16'd1) begin
                        n_seq_ok = 1'b1;
                        n_good   = r_good[sel] + 32'd1;
                    end else begin
                        n_seq_ok = 1'b0;
                        n_lost   = r_lost[sel] + 32'd1;
                    end
                    n_seq_base   = i_word.frame_seq;
                    n_held_len   = i_word.frame_len[LEN_W-1:0];
                    n_held_valid = 1'b1;
                    n_ok_total   = r_ok_total + 32'd1;
                    if (rep) begin
                        n_rep_total = r_rep_total + 32'd1;
                    end
                end
                ST_SRC_ERR: n_src_total = r_src_total + 32'd1;
                ST_LEN_ERR: n_len_total = r_len_total + 32'd1;
                ST_POLL_DONE: begin
                    // Stale-tag check runs once per period
                    if (!r_polled[sel]) begin
                        stale = r_seq_ok[sel] && r_prev_ok[sel]
                             && (r_prev_tag[sel] == r_tag[sel]);
                        if (stale) begin
                            n_seq_ok     = 1'b0;
                            n_held_valid = 1'b0;
                        end
                        n_prev_ok  = n_seq_ok;
                        n_prev_tag = r_tag[sel];
                        n_polled   = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Commit the selected port and the totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PORTS; i++) begin
                r_seq_base[i]   <= '0;
                r_held_valid[i] <= 1'b0;
                r_held_len[i]   <= '0;
                r_tag[i]        <= '0;
                r_seq_ok[i]     <= 1'b0;
                r_prev_ok[i]    <= 1'b0;
                r_prev_tag[i]   <= '0;
                r_polled[i]     <= 1'b0;
                r_lost[i]       <= '0;
                r_good[i]       <= '0;
            end
            r_ok_total  <= '0;
            r_rep_total <= '0;
            r_src_total <= '0;
            r_len_total <= '0;
        end else if (i_fire) begin
            if (i_chk.has_result && i_chk.port_known) begin
                r_seq_base[sel]   <= n_seq_base;
                r_held_valid[sel] <= n_held_valid;
                r_held_len[sel]   <= n_held_len;
                r_tag[sel]        <= n_tag;
                r_seq_ok[sel]     <= n_seq_ok;
                r_prev_ok[sel]    <= n_prev_ok;
                r_prev_tag[sel]   <= n_prev_tag;
                r_polled[sel]     <= n_polled;
                r_lost[sel]       <= n_lost;
                r_good[sel]       <= n_good;
            end
            // Re-arm the polls of every port
            if (i_chk.has_result && (i_chk.status == ST_PERIOD)) begin
                for (int i = 0; i < PORTS; i++) begin
                    r_polled[i] <= 1'b0;
                end
            end
            r_ok_total  <= n_ok_total;
            r_rep_total <= n_rep_total;
            r_src_total <= n_src_total;
            r_len_total <= n_len_total;
        end
    end

    // Build the result from the state after the word
    always_comb begin
        o_result                  = '0;
        o_result.status           = i_chk.status;
        o_result.ok_total         = n_ok_total;
        o_result.repeat_total     = n_rep_total;
        o_result.source_err_total = n_src_total;
        o_result.length_err_total = n_len_total;
        if (i_chk.port_known) begin
            o_result.port        = i_chk.pidx;
            o_result.repeat_res  = rep;
            o_result.in_sequence = n_seq_ok;
            o_result.data_held   = n_held_valid;
            o_result.lost_count  = n_lost;
            o_result.good_count  = n_good;
            o_result.held_tag    = n_tag;
        end
    end

endmodule

FILE: bench/tb_redundant_frame_rx_checker_core.sv
// Testbench for redundant_frame_rx_checker_core: directed sequence, repeat, header,
// length and poll cases, then random traffic under several register settings, checked
// against a port model. Depends on rfrc_pkg and the checker RTL only.
`timescale 1ns / 100ps

module tb_redundant_frame_rx_checker_core;
    import rfrc_pkg::*;

    localparam int NPORTS       = RFRC_PORTS;
    localparam int MAXLEN       = RFRC_MAX_LEN;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_WORDS  = 85;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    t_in_word             i_in_word = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_word            o_out_word;
    logic                 i_out_stall = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Register copies as last written
    bit [7:0]             cfg_slot;
    bit [7:0]             cfg_type;
    bit [7:0]             cfg_first;
    bit [CFG_LEN_W-1:0]   cfg_len;

    // Port model state
    bit [15:0]            last_seq     [NPORTS];
    bit                   held_ok      [NPORTS];
    bit [10:0]            held_length  [NPORTS];
    bit [31:0]            held_tags    [NPORTS];
    bit                   seq_good     [NPORTS];
    bit                   good_at_poll [NPORTS];
    bit [31:0]            tag_at_poll  [NPORTS];
    bit                   polled       [NPORTS];
    bit [31:0]            lost_cnt     [NPORTS];
    bit [31:0]            good_cnt     [NPORTS];
    bit [31:0]            n_ok, n_repeat, n_src, n_len;

    // Run statistics
    int                   n_polls, n_periods, n_stale, n_ignored, n_settings, n_words;
    int                   mismatches;
    bit                   idle_on;

    t_out_word            due_reports[$];

    redundant_frame_rx_checker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stall the result side at random while idling is enabled
    always @(posedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < 15);
    end

    // Advance the port model by one accepted word and queue its report
    task automatic update_port_state(input t_in_word w);
        t_out_word r;
        int        p;
        int        lim;
        bit        known;
        bit        rep;
        r     = '0;
        p     = 0;
        known = 1'b0;
        rep   = 1'b0;
        lim   = (int'(cfg_len) > MAXLEN) ? MAXLEN : int'(cfg_len);
        n_words++;
        case (w.mode)
            MODE_FRAME: begin
                if (!w.right_train || w.delivered_slot != cfg_slot || w.frame_type != cfg_type
                    || w.header_slot != cfg_slot || w.source_port < cfg_first
                    || int'(w.source_port) >= int'(cfg_first) + NPORTS) begin
                    n_src++;
                    r.status = ST_SRC_ERR;
                end else begin
                    p     = int'(w.source_port) - int'(cfg_first);
                    known = 1'b1;
                    if ((lim != 0 && int'(w.frame_len) != lim) || w.frame_len == 16'd0
                        || int'(w.frame_len) > MAXLEN) begin
                        n_len++;
                        r.status = ST_LEN_ERR;
                    end else begin
                        rep = held_ok[p] && held_length[p] == w.frame_len
                              && held_tags[p] == w.frame_tag;
                        held_tags[p] = w.frame_tag;
                        if (w.frame_seq != 16'(last_seq[p] + 16'd1)) begin
                            seq_good[p] = 1'b0;
                            lost_cnt[p]++;
                        end else begin
                            seq_good[p] = 1'b1;
                            good_cnt[p]++;
                        end
                        last_seq[p]    = w.frame_seq;
                        held_length[p] = 11'(w.frame_len);
                        held_ok[p]     = 1'b1;
                        n_ok++;
                        if (rep) n_repeat++;
                        r.status = ST_ACCEPT;
                    end
                end
            end
            MODE_POLL: begin
                n_polls++;
                if (w.poll_port >= NPORTS) begin
                    r.status = ST_POLL_BAD;
                end else begin
                    p     = int'(w.poll_port);
                    known = 1'b1;
                    // Stale check runs once per period; later polls only report
                    if (!polled[p]) begin
                        if (seq_good[p] && good_at_poll[p] && tag_at_poll[p] == held_tags[p]) begin
                            seq_good[p] = 1'b0;
                            held_ok[p]  = 1'b0;
                            n_stale++;
                        end
                        good_at_poll[p] = seq_good[p];
                        tag_at_poll[p]  = held_tags[p];
                        polled[p]       = 1'b1;
                    end
                    r.status = ST_POLL_DONE;
                end
            end
            MODE_PERIOD: begin
                n_periods++;
                polled   = '{default: 1'b0};
                r.status = ST_PERIOD;
            end
            default: begin
                n_ignored++;
                return;
            end
        endcase
        if (known) begin
            r.port        = 4'(p);
            r.repeat_res  = rep;
            r.in_sequence = seq_good[p];
            r.data_held   = held_ok[p];
            r.lost_count  = lost_cnt[p];
            r.good_count  = good_cnt[p];
            r.held_tag    = held_tags[p];
        end
        r.ok_total         = n_ok;
        r.repeat_total     = n_repeat;
        r.source_err_total = n_src;
        r.length_err_total = n_len;
        due_reports.push_back(r);
    endtask

    task automatic report_field(input string fname, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
        end
    endtask

    // Compare each result word with the oldest pending report
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with none pending: %p", $time, o_out_word);
            end else begin
                want = due_reports.pop_front();
                report_field("status", want.status, o_out_word.status);
                report_field("port", want.port, o_out_word.port);
                report_field("repeat_res", want.repeat_res, o_out_word.repeat_res);
                report_field("in_sequence", want.in_sequence, o_out_word.in_sequence);
                report_field("data_held", want.data_held, o_out_word.data_held);
                report_field("lost_count", want.lost_count, o_out_word.lost_count);
                report_field("good_count", want.good_count, o_out_word.good_count);
                report_field("held_tag", want.held_tag, o_out_word.held_tag);
                report_field("ok_total", want.ok_total, o_out_word.ok_total);
                report_field("repeat_total", want.repeat_total, o_out_word.repeat_total);
                report_field("source_err_total", want.source_err_total,
                             o_out_word.source_err_total);
                report_field("length_err_total", want.length_err_total,
                             o_out_word.length_err_total);
            end
        end
    end

    // Send one word, with a random gap ahead of it while idling is enabled
    task automatic send_word(input t_in_word w);
        if (idle_on && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        update_port_state(w);
    endtask

    // Hold the sender until every pending report is back, then let the pipe settle
    task automatic pause_until_drained();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_reports.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (due_reports.size() != 0) begin
            mismatches += due_reports.size();
            $display("%0t: %0d result words never arrived", $time, due_reports.size());
            due_reports.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_EXPECTED_SLOT:   cfg_slot  = val[7:0];
            REG_FRAME_TYPE_CODE: cfg_type  = val[7:0];
            REG_FIRST_PORT:      cfg_first = val[7:0];
            REG_CONFIGURED_LEN:  cfg_len   = val[CFG_LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] slot, input logic [7:0] type_code,
                              input logic [7:0] first, input logic [CFG_LEN_W-1:0] len);
        cfg_write(REG_EXPECTED_SLOT, 32'(slot));
        cfg_write(REG_FRAME_TYPE_CODE, 32'(type_code));
        cfg_write(REG_FIRST_PORT, 32'(first));
        cfg_write(REG_CONFIGURED_LEN, 32'(len));
        n_settings++;
    endtask

    // Well-formed header under the current settings
    function automatic t_in_word frame_word(input logic [7:0] sport, input logic [15:0] len,
                                            input logic [15:0] seq, input logic [31:0] tag);
        t_in_word w;
        w                = '0;
        w.mode           = MODE_FRAME;
        w.right_train    = 1'b1;
        w.delivered_slot = cfg_slot;
        w.frame_type     = cfg_type;
        w.header_slot    = cfg_slot;
        w.source_port    = sport;
        w.frame_len      = len;
        w.frame_seq      = seq;
        w.frame_tag      = tag;
        return w;
    endfunction

    function automatic t_in_word ctrl_word(input logic [1:0] mode, input logic [7:0] pport);
        t_in_word w;
        w           = '0;
        w.mode      = mode;
        w.poll_port = pport;
        return w;
    endfunction

    // Mostly valid frames in sequence, plus broken headers, lengths and other modes
    function automatic t_in_word random_word();
        t_in_word w;
        int       pick;
        int       span;
        int       idx;
        int       top;
        pick = $urandom_range(99);
        span = 255 - int'(cfg_first);
        if (span > NPORTS - 1) span = NPORTS - 1;
        idx = $urandom_range(span);
        top = (int'(cfg_len) > MAXLEN) ? MAXLEN : int'(cfg_len);
        w.mode           = MODE_FRAME;
        w.right_train    = 1'b1;
        w.delivered_slot = cfg_slot;
        w.frame_type     = cfg_type;
        w.header_slot    = cfg_slot;
        w.source_port    = 8'(int'(cfg_first) + idx);
        if (top != 0) begin
            w.frame_len = 16'(top);
        end else begin
            case ($urandom_range(3))
                0: w.frame_len = 16'd1;
                1: w.frame_len = 16'd64;
                2: w.frame_len = 16'(MAXLEN);
                default: w.frame_len = 16'($urandom_range(1, MAXLEN));
            endcase
        end
        w.frame_seq = ($urandom_range(9) < 8) ? 16'(last_seq[idx] + 16'd1) : 16'($urandom);
        w.frame_tag = ($urandom_range(9) < 3) ? held_tags[idx] : 32'($urandom);
        w.poll_port = 8'($urandom);
        if (pick < 60) return w;
        if (pick < 70) begin
            // Break one source field
            case ($urandom_range(5))
                0: w.right_train = 1'b0;
                1: w.delivered_slot ^= 8'($urandom_range(1, 255));
                2: w.frame_type ^= 8'($urandom_range(1, 255));
                3: w.header_slot ^= 8'($urandom_range(1, 255));
                4: begin
                    if (cfg_first != 8'd0)
                        w.source_port = 8'($urandom_range(int'(cfg_first) - 1));
                    else
                        w.right_train = 1'b0;
                end
                default: begin
                    if (int'(cfg_first) + NPORTS <= 255)
                        w.source_port = 8'($urandom_range(int'(cfg_first) + NPORTS, 255));
                    else
                        w.right_train = 1'b0;
                end
            endcase
        end else if (pick < 78) begin
            // Break the length
            case ($urandom_range(2))
                0: w.frame_len = 16'd0;
                1: w.frame_len = 16'($urandom_range(MAXLEN + 1, 65535));
                default: begin
                    if (top != 0)
                        w.frame_len = 16'((top - 1 + $urandom_range(1, MAXLEN - 1)) % MAXLEN + 1);
                    else
                        w.frame_len = 16'hFFFF;
                end
            endcase
        end else if (pick < 90) begin
            w.mode      = MODE_POLL;
            w.poll_port = ($urandom_range(9) < 9) ? 8'($urandom_range(NPORTS - 1))
                                                   : 8'($urandom);
        end else if (pick < 95) begin
            w.mode = MODE_PERIOD;
        end else if (pick < 97) begin
            w.mode = MODE_UNUSED;
        end else begin
            // Pure noise on every field
            w.mode           = 2'($urandom);
            w.right_train    = 1'($urandom);
            w.delivered_slot = 8'($urandom);
            w.frame_type     = 8'($urandom);
            w.header_slot    = 8'($urandom);
            w.source_port    = 8'($urandom);
            w.frame_len      = 16'($urandom);
            w.frame_seq      = 16'($urandom);
            w.frame_tag      = $urandom;
        end
        return w;
    endfunction

    // In-sequence, lost, wrapped and repeated frames
    task automatic test_sequence_and_repeat();
        send_word(frame_word(8'd10, 16'd1, 16'd1, 32'h0000_0000));
        send_word(frame_word(8'd10, 16'd1, 16'd2, 32'h0000_0000));
        send_word(frame_word(8'd13, 16'(MAXLEN), 16'hFFFF, 32'hFFFF_FFFF));
        send_word(frame_word(8'd13, 16'(MAXLEN), 16'h0000, 32'hFFFF_FFFF));
        send_word(frame_word(8'd11, 16'd512, 16'd7, 32'h0000_1234));
    endtask

    // Each source field wrong on its own, port range just outside on both sides
    task automatic test_source_checks();
        t_in_word w;
        w = frame_word(8'd12, 16'd8, 16'd3, 32'h55);
        w.right_train = 1'b0;
        send_word(w);
        w = frame_word(8'd12, 16'd8, 16'd3, 32'h55);
        w.delivered_slot = ~cfg_slot;
        send_word(w);
        w = frame_word(8'd12, 16'd8, 16'd3, 32'h55);
        w.frame_type = ~cfg_type;
        send_word(w);
        w = frame_word(8'd12, 16'd8, 16'd3, 32'h55);
        w.header_slot = ~cfg_slot;
        send_word(w);
        send_word(frame_word(8'd9, 16'd8, 16'd3, 32'h55));
        send_word(frame_word(8'd14, 16'd8, 16'd3, 32'h55));
    endtask

    // Zero, just-oversize and all-ones lengths, then a fixed configured length
    task automatic test_length_checks();
        send_word(frame_word(8'd12, 16'd0, 16'd1, 32'h77));
        send_word(frame_word(8'd12, 16'(MAXLEN + 1), 16'd1, 32'h77));
        send_word(frame_word(8'd12, 16'hFFFF, 16'd1, 32'h77));
        pause_until_drained();
        set_config(cfg_slot, cfg_type, cfg_first, 11'd100);
        send_word(frame_word(8'd12, 16'd99, 16'd1, 32'h77));
        send_word(frame_word(8'd12, 16'd100, 16'd1, 32'h77));
    endtask

    // Poll twice per period, restart, hit a stale tag, then bad poll ports, unused mode
    task automatic test_poll_stale();
        send_word(ctrl_word(MODE_POLL, 8'd0));
        send_word(ctrl_word(MODE_POLL, 8'd0));
        send_word(ctrl_word(MODE_PERIOD, 8'd0));
        send_word(ctrl_word(MODE_POLL, 8'd0));
        send_word(ctrl_word(MODE_POLL, 8'd1));
        send_word(ctrl_word(MODE_POLL, 8'(NPORTS)));
        send_word(ctrl_word(MODE_POLL, 8'hFF));
        send_word(ctrl_word(MODE_UNUSED, 8'd0));
    endtask

    // Random traffic over several settings, extremes included
    task automatic test_random_traffic();
        t_in_word w;
        int       sent;
        for (int ph = 0; ph < 6; ph++) begin
            pause_until_drained();
            case (ph)
                0: set_config(8'h00, 8'h00, 8'h00, 11'd0);
                1: set_config(8'hFF, 8'hFF, 8'(256 - NPORTS), 11'(MAXLEN));
                2: set_config(8'($urandom), 8'($urandom), 8'hFF, 11'd0);
                3: set_config(8'($urandom), 8'($urandom), 8'($urandom_range(200)), 11'h7FF);
                4: set_config(8'($urandom), 8'($urandom), 8'($urandom),
                              11'($urandom_range(1, MAXLEN)));
                default: set_config(8'($urandom), 8'($urandom), 8'($urandom), 11'd0);
            endcase
            // Run the last phase back to back on both sides
            idle_on = (ph != 5);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                w = random_word();
                send_word(w);
                if (w.mode != MODE_UNUSED) begin
                    sent++;
                    if (ph == 2 && sent == PHASE_WORDS / 2) pause_until_drained();
                end
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        idle_on = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_config(8'h5A, 8'hC3, 8'd10, 11'd0);
        test_sequence_and_repeat();
        test_source_checks();
        test_length_checks();
        test_poll_stale();
        test_random_traffic();
        pause_until_drained();
        $display("Covered %0d words under %0d settings: %0d accepted, %0d repeats, %0d source and %0d length errors.",
                 n_words, n_settings, n_ok, n_repeat, n_src, n_len);
        $display("Polls %0d with %0d stale clears, %0d period restarts, %0d ignored, %0d mismatches.",
                 n_polls, n_stale, n_periods, n_ignored, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Bound the run well past the slowest legal schedule
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: redundant_frame_rx_checker_core.f
hw/rtl/rfrc_pkg.sv
hw/rtl/rfrc_cfg_regs.sv
hw/rtl/rfrc_frame_check.sv
hw/rtl/rfrc_port_state.sv
hw/rtl/redundant_frame_rx_checker_core.sv
bench/tb_redundant_frame_rx_checker_core.sv
